/* rtl/button_press_long_press_fsm_macros.svh */
// assertion macros for the button detector checker
`ifndef BUTTON_PRESS_LONG_PRESS_FSM_MACROS_SVH
`define BUTTON_PRESS_LONG_PRESS_FSM_MACROS_SVH

// same-cycle implication, masked during reset
`define BPLP_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define BPLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers the reset cycles
`define BPLP_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bplp_pkg.sv */
// shared types and constants for the button press / long press detector
package bplp_pkg;

   localparam int ID_W       = 2;
   localparam int POLLS_W    = 7;
   localparam int CD_W       = 8;
   localparam int LONG_PRESS_MS = 2000;
   localparam int POLL_MS       = 100;
   localparam int NUM_BUTTONS_DEFAULT = 4;
   localparam logic [POLLS_W-1:0] POLLS_RESET = POLLS_W'(LONG_PRESS_MS / POLL_MS);

   typedef enum logic [1:0] {
      ST_UNPRESSED  = 2'd0,
      ST_DEBOUNCING = 2'd1,
      ST_PRESS      = 2'd2,
      ST_LONG_PRESS = 2'd3
   } btn_state_type;

   typedef enum logic [1:0] {
      IND_NONE    = 2'd0,
      IND_PRESS   = 2'd1,
      IND_RELEASE = 2'd2,
      IND_LONG    = 2'd3
   } ind_type;

   typedef enum logic [1:0] {
      IRQ_KEEP    = 2'd0,
      IRQ_ENABLE  = 2'd1,
      IRQ_DISABLE = 2'd2
   } irq_type;

   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_POLL = 1'b1
   } op_type;

   typedef struct packed {
      btn_state_type    state;
      logic [CD_W-1:0]  countdown;
   } btn_rec_type;

   typedef struct packed {
      logic         wr_en;
      btn_rec_type  rec;
      ind_type      indication;
      irq_type      irq_command;
      logic         timer_restart;
   } step_out_type;

endpackage

/* rtl/button_press_long_press_fsm.sv */
// button debounce and long press detector top level
// a request is registered in the input stage, then its result in the response stage
// throughput: one request per cycle unless the response stalls; the table read-modify-write
// reads combinationally and writes at the same edge the response register loads, so a following
// request for the same button sees the updated state with no bubble
// reset: synchronous, clears all buttons to unpressed with zero countdown, long press polls to 20
module button_press_long_press_fsm
   import bplp_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [ID_W-1:0]     req_button_id,
   input  logic                req_level_pressed,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ID_W-1:0]     rsp_result_button,
   output logic [1:0]          rsp_indication,
   output logic [1:0]          rsp_irq_command,
   output logic                rsp_timer_restart,
   // configuration write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [POLLS_W-1:0]  csr_long_press_polls
);

   localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   // long press threshold register
   logic [POLLS_W-1:0] polls_ff, polls_in;

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   op_type             s1_op_ff;
   logic [ID_W-1:0]    s1_id_ff;
   logic               s1_lvl_ff;

   // response stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_button_ff;
   ind_type            rsp_ind_ff;
   irq_type            rsp_irq_ff;
   logic               rsp_tmr_ff;

   logic               s1_adv;
   logic               req_take;
   logic               in_range;
   logic [IdxW-1:0]    s1_idx;
   btn_rec_type        cur_rec;
   step_out_type       step_out;

   // the stage moves forward when the response register is empty or being drained
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // ids past the configured button count touch no state
   assign in_range = int'(s1_id_ff) < NUM_BUTTONS;
   assign s1_idx   = IdxW'(s1_id_ff);

   always_comb begin
      polls_in     = csr_valid ? csr_long_press_polls : polls_ff;
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   bplp_btn_table #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (s1_idx),
      .rd_rec (cur_rec),
      .wr_en  (s1_adv && step_out.wr_en),
      .wr_idx (s1_idx),
      .wr_rec (step_out.rec)
   );

   bplp_step u_step (
      .in_range         (in_range),
      .opcode           (s1_op_ff),
      .level_pressed    (s1_lvl_ff),
      .cur_rec          (cur_rec),
      .long_press_polls (polls_ff),
      .step_out         (step_out)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         polls_ff     <= POLLS_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         polls_ff     <= polls_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff  <= op_type'(req_opcode);
         s1_id_ff  <= req_button_id;
         s1_lvl_ff <= req_level_pressed;
      end
      if (s1_adv) begin
         rsp_button_ff <= s1_id_ff;
         rsp_ind_ff    <= step_out.indication;
         rsp_irq_ff    <= step_out.irq_command;
         rsp_tmr_ff    <= step_out.timer_restart;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_button = rsp_button_ff;
   assign rsp_indication    = rsp_ind_ff;
   assign rsp_irq_command   = rsp_irq_ff;
   assign rsp_timer_restart = rsp_tmr_ff;

endmodule

/* rtl/bplp_btn_table.sv */
// per-button state and poll countdown storage, one read and one write port
module bplp_btn_table
   import bplp_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [(NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1)-1:0] rd_idx,
   output btn_rec_type         rd_rec,
   input  logic                wr_en,
   input  logic [(NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1)-1:0] wr_idx,
   input  btn_rec_type         wr_rec
);

   btn_rec_type rec_ff [NUM_BUTTONS];

   assign rd_rec = rec_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            rec_ff[i] <= '{state: ST_UNPRESSED, countdown: '0};
         end
      end else if (wr_en) begin
         rec_ff[wr_idx] <= wr_rec;
      end
   end

endmodule

/* rtl/bplp_step.sv */
// next-state and result logic for one button event
module bplp_step
   import bplp_pkg::*;
(
   input  logic                in_range,
   input  op_type              opcode,
   input  logic                level_pressed,
   input  btn_rec_type         cur_rec,
   input  logic [POLLS_W-1:0]  long_press_polls,
   output step_out_type        step_out
);

   logic [CD_W-1:0] cd_dec;
   logic [CD_W-1:0] cd_load;

   assign cd_dec  = cur_rec.countdown - CD_W'(1);
   assign cd_load = CD_W'(long_press_polls) - CD_W'(1);

   always_comb begin
      step_out.wr_en         = in_range;
      step_out.rec           = cur_rec;
      step_out.indication    = IND_NONE;
      step_out.irq_command   = IRQ_KEEP;
      step_out.timer_restart = 1'b0;
      if (in_range) begin
         if (opcode == OP_EDGE) begin
            step_out.rec.state     = ST_DEBOUNCING;
            step_out.irq_command   = IRQ_DISABLE;
            step_out.timer_restart = 1'b1;
         end else begin
            unique case (cur_rec.state)
               ST_PRESS: begin
                  if (!level_pressed) begin
                     step_out.rec.state   = ST_UNPRESSED;
                     step_out.irq_command = IRQ_ENABLE;
                     step_out.indication  = IND_RELEASE;
                  end else begin
                     step_out.rec.countdown = cd_dec;
                     // signed countdown at or below zero
                     if (cd_dec[CD_W-1] || (cd_dec == '0)) begin
                        step_out.rec.state  = ST_LONG_PRESS;
                        step_out.indication = IND_LONG;
                     end
                     step_out.timer_restart = 1'b1;
                  end
               end
               ST_LONG_PRESS: begin
                  if (!level_pressed) begin
                     step_out.rec.state   = ST_UNPRESSED;
                     step_out.irq_command = IRQ_ENABLE;
                     step_out.indication  = IND_RELEASE;
                  end else begin
                     step_out.timer_restart = 1'b1;
                  end
               end
               ST_UNPRESSED, ST_DEBOUNCING: begin
                  if (level_pressed) begin
                     step_out.rec.state     = ST_PRESS;
                     step_out.rec.countdown = cd_load;
                     step_out.indication    = IND_PRESS;
                     step_out.timer_restart = 1'b1;
                  end else begin
                     step_out.rec.state   = ST_UNPRESSED;
                     step_out.irq_command = IRQ_ENABLE;
                  end
               end
            endcase
         end
      end
   end

endmodule

/* rtl/bplp_checker.sv */
// port-level checker for the button detector, bound to the top level
`include "button_press_long_press_fsm_macros.svh"

module bplp_checker
   import bplp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [ID_W-1:0]     rsp_result_button,
   input  logic [1:0]          rsp_indication,
   input  logic [1:0]          rsp_irq_command,
   input  logic                rsp_timer_restart
);

   logic       is_press;
   logic       is_release;
   logic       press_ok;
   logic       release_ok;
   logic       rsp_stall;
   logic [6:0] rsp_payload;

   assign is_press    = rsp_valid && (rsp_indication == IND_PRESS);
   assign is_release  = rsp_valid && (rsp_indication == IND_RELEASE);
   assign press_ok    = rsp_timer_restart && (rsp_irq_command == IRQ_KEEP);
   assign release_ok  = !rsp_timer_restart && (rsp_irq_command == IRQ_ENABLE);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_result_button, rsp_indication, rsp_irq_command,
                         rsp_timer_restart};

   // a press always restarts the timer and leaves the interrupt alone
   `BPLP_ASSERT(a_press_restarts, is_press, press_ok, "press without timer restart")

   // a release re-enables the interrupt and stops polling
   `BPLP_ASSERT(a_release_enables, is_release, release_ok, "release without interrupt enable")

   // a stalled response holds
   `BPLP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // nothing is presented right after reset
   `BPLP_ASSERT_RST(a_reset_empty, reset, !rsp_valid, "response valid after reset")

endmodule

bind button_press_long_press_fsm bplp_checker u_bplp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_button (rsp_result_button),
   .rsp_indication    (rsp_indication),
   .rsp_irq_command   (rsp_irq_command),
   .rsp_timer_restart (rsp_timer_restart)
);
